[hdl/mtd_pkg.sv]
package mtd_pkg;

    localparam int TREE_ENTRIES = 64;

    localparam logic [14:0] RESET_MIN_THRESHOLD = 15'd100;
    localparam logic [7:0]  RESET_INITIAL_DIT   = 8'd8;
    localparam logic [5:0]  TREE_ROOT           = 6'd1;
    localparam logic [7:0]  RUN_MAX             = 8'd255;
    localparam logic [6:0]  CHAR_SPACE          = 7'h20;

    // binary morse tree, dit goes to 2n, dah to 2n+1
    localparam logic [7:0] TREE_SYMBOLS [0:TREE_ENTRIES-1] = '{
        8'd0, 8'd0, "E",  "T",  "I",  "A",  "N",  "M",
        "S",  "U",  "R",  "W",  "D",  "K",  "G",  "O",
        "H",  "V",  "F",  8'd0, "L",  8'd0, "P",  "J",
        "B",  "X",  "C",  "Y",  "Z",  "Q",  8'd0, 8'd0,
        "5",  "4",  8'd0, "3",  8'd0, 8'd0, 8'd0, "2",
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, "1",
        "6",  "=",  "/",  8'd0, 8'd0, 8'd0, "(",  8'd0,
        "7",  8'd0, "8",  8'd0, "9",  "0",  8'd0, 8'd0
    };

    typedef struct packed {
        logic [6:0] character;
        logic       last;
    } result_t;

    // up to two results written into the queue by one item
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

[hdl/mtd_result_queue.sv]
module mtd_result_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mtd_pkg::push_t  push,
    output logic            room_for_two,
    output logic            result_valid,
    input  logic            result_ready,
    output mtd_pkg::result_t result
);
    import mtd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_plus1;
    logic               pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);
    assign pop          = result_valid && result_ready;
    assign result_valid = (count_reg != '0);
    assign result       = mem[rd_ptr_reg];
    assign room_for_two = (count_reg <= CNT_W'(DEPTH - 2));

    always_comb
    begin
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        unique case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_plus1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room_for_two)
        else $error("item pushed without room for two results");

    a_double_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2 && !pop) |=> count_reg == $past(count_reg) + CNT_W'(2))
        else $error("double push lost an entry");

endmodule

[hdl/morse_tone_decoder_unit.sv]
// Adaptive morse decoder: takes one amplitude sample per item and can accept
// a new sample every clock cycle. All per-sample work (average, threshold,
// mark/space classification, tree step, dit adaptation) is done in the cycle
// the sample is accepted; its results (0, 1 or 2 characters, last set on the
// final one) are written into a small result queue of QUEUE_DEPTH entries
// that drives the result port. sample_ready drops while that queue has fewer
// than two free entries and during the access cycle of a register write, so
// the sustained rate is one sample per cycle as long as results are drained
// about as fast as they come.
// Register writes (min_threshold at 0x0, initial_dit at 0x4) reload the
// average or the dit estimate and are meant for an idle block.
module morse_tone_decoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  logic [14:0] amplitude,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [6:0]  character,
    output logic        last
);
    import mtd_pkg::*;

    localparam logic REG_MIN_THRESHOLD = 1'b0;
    localparam logic REG_INITIAL_DIT   = 1'b1;

    logic [14:0] min_threshold_reg, min_threshold_next;
    logic [7:0]  initial_dit_reg, initial_dit_next;
    logic [17:0] amp_average_reg, amp_average_next;
    logic [7:0]  dit_length_reg, dit_length_next;
    logic        tone_present_reg, tone_present_next;
    logic [7:0]  run_ticks_reg, run_ticks_next;
    logic [5:0]  tree_node_reg, tree_node_next;

    logic        cfg_write;
    logic        queue_room;
    logic        sample_accept;
    logic [21:0] average_sum;
    logic [17:0] average_new;
    logic [14:0] threshold;
    logic        mark;
    logic [8:0]  dit_limit;
    logic        is_dit;
    logic [15:0] third_product;
    logic [7:0]  run_third;
    logic [9:0]  dit_sum;
    logic [10:0] dit_times7;
    logic [8:0]  dit_times2;
    logic [7:0]  tree_entry;
    logic        has_symbol;
    logic        word_gap;
    logic        char_gap;
    push_t       push;
    result_t     result;

    assign pready        = 1'b1;
    assign cfg_write     = psel && penable && pwrite && pready;
    // a register write and a sample never land on the same edge
    assign sample_ready  = queue_room && !cfg_write;
    assign sample_accept = sample_valid && sample_ready;

    always_comb
    begin
        unique case (paddr[2])
            REG_MIN_THRESHOLD: prdata = {17'd0, min_threshold_reg};
            REG_INITIAL_DIT:   prdata = {24'd0, initial_dit_reg};
            default:           prdata = '0;
        endcase
    end

    // average * 7 + amplitude * 8, then back down by eight
    assign average_sum = {1'b0, amp_average_reg, 3'b000} - {4'd0, amp_average_reg}
                       + {4'd0, amplitude, 3'b000};
    assign average_new = average_sum[20:3];
    assign threshold   = (average_new[17:3] < min_threshold_reg) ? min_threshold_reg
                                                                 : average_new[17:3];
    assign mark        = amplitude > threshold;

    assign dit_limit     = {1'b0, dit_length_reg} + {2'b00, dit_length_reg[7:1]};
    assign is_dit        = {1'b0, run_ticks_reg} <= dit_limit;
    // run / 3 as a multiply by 171/512, exact for 8-bit values
    assign third_product = run_ticks_reg * 8'd171;
    assign run_third     = {1'b0, third_product[15:9]};
    assign dit_sum       = {1'b0, dit_length_reg, 1'b0} + {2'b00, dit_length_reg}
                         + {2'b00, (is_dit ? run_ticks_reg : run_third)};

    assign dit_times7 = {dit_length_reg, 3'b000} - {3'b000, dit_length_reg};
    assign dit_times2 = {dit_length_reg, 1'b0};
    assign word_gap   = {3'b000, run_ticks_reg} >= dit_times7;
    assign char_gap   = {1'b0, run_ticks_reg} >= dit_times2;

    assign tree_entry = TREE_SYMBOLS[tree_node_reg];
    assign has_symbol = (tree_entry != 8'd0);

    always_comb
    begin
        min_threshold_next = min_threshold_reg;
        initial_dit_next   = initial_dit_reg;
        amp_average_next   = amp_average_reg;
        dit_length_next    = dit_length_reg;
        tone_present_next  = tone_present_reg;
        run_ticks_next     = run_ticks_reg;
        tree_node_next     = tree_node_reg;
        push               = '0;

        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_MIN_THRESHOLD:
                begin
                    min_threshold_next = pwdata[14:0];
                    amp_average_next   = {pwdata[14:0], 3'b000};
                end
                REG_INITIAL_DIT:
                begin
                    initial_dit_next = pwdata[7:0];
                    dit_length_next  = pwdata[7:0];
                end
                default:
                begin
                end
            endcase
        end
        else if (sample_accept)
        begin
            amp_average_next = average_new;
            if (mark == tone_present_reg)
            begin
                if (run_ticks_reg != RUN_MAX)
                begin
                    run_ticks_next = run_ticks_reg + 8'd1;
                end
            end
            else
            begin
                tone_present_next = mark;
                run_ticks_next    = '0;
                if (tone_present_reg)
                begin
                    // full tree: further marks are ignored
                    if (!tree_node_reg[5])
                    begin
                        tree_node_next  = {tree_node_reg[4:0], !is_dit};
                        dit_length_next = dit_sum[9:2];
                    end
                end
                else
                begin
                    priority if (word_gap)
                    begin
                        tree_node_next = TREE_ROOT;
                        if (has_symbol)
                        begin
                            push.count  = 2'd2;
                            push.first  = '{character: tree_entry[6:0], last: 1'b0};
                            push.second = '{character: CHAR_SPACE, last: 1'b1};
                        end
                        else
                        begin
                            push.count = 2'd1;
                            push.first = '{character: CHAR_SPACE, last: 1'b1};
                        end
                    end
                    else if (char_gap)
                    begin
                        tree_node_next = TREE_ROOT;
                        if (has_symbol)
                        begin
                            push.count = 2'd1;
                            push.first = '{character: tree_entry[6:0], last: 1'b1};
                        end
                    end
                    else
                    begin
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_threshold_reg <= RESET_MIN_THRESHOLD;
            initial_dit_reg   <= RESET_INITIAL_DIT;
            amp_average_reg   <= {RESET_MIN_THRESHOLD, 3'b000};
            dit_length_reg    <= RESET_INITIAL_DIT;
            tone_present_reg  <= 1'b0;
            run_ticks_reg     <= '0;
            tree_node_reg     <= TREE_ROOT;
        end
        else
        begin
            min_threshold_reg <= min_threshold_next;
            initial_dit_reg   <= initial_dit_next;
            amp_average_reg   <= amp_average_next;
            dit_length_reg    <= dit_length_next;
            tone_present_reg  <= tone_present_next;
            run_ticks_reg     <= run_ticks_next;
            tree_node_reg     <= tree_node_next;
        end
    end

    mtd_result_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room_for_two (queue_room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    assign character = result.character;
    assign last      = result.last;

    a_node_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        tree_node_reg != 6'd0)
        else $error("tree node left the tree");

    a_change_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_accept && !cfg_write && mark != tone_present_reg) |=> run_ticks_reg == '0)
        else $error("run counter not cleared on tone change");

    a_full_tree_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_accept && !cfg_write && tone_present_reg && !mark && tree_node_reg[5])
        |=> (tree_node_reg == $past(tree_node_reg)
             && dit_length_reg == $past(dit_length_reg)))
        else $error("mark on a full tree changed decoder state");

endmodule

[sim/morse_tone_decoder_checker.sv]
`timescale 1ns / 1ps

package mtd_tb_pkg;

    // register byte addresses on the config port
    localparam logic [2:0] ADDR_MIN_THRESHOLD = 3'd0;
    localparam logic [2:0] ADDR_INITIAL_DIT   = 3'd4;

endpackage

module morse_tone_decoder_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        sample_valid,
    input  logic        sample_ready,
    input  logic [14:0] amplitude,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [6:0]  character,
    input  logic        last,
    output int          fail_count,
    output int          pending
);
    import mtd_tb_pkg::*;

    localparam logic [5:0] TREE_FULL = 6'd32;

    logic [14:0] floor_level;
    logic [17:0] amp_avg;
    logic [7:0]  dit_est;
    logic        tone_on;
    logic [7:0]  run_len;
    logic [5:0]  node;

    mtd_pkg::result_t expected_chars [$];
    mtd_pkg::result_t want;

    task automatic report_mismatch(input string what);
        $display("checker: %s at %0t", what, $time);
        fail_count++;
    endtask

    // one amplitude tick: average, threshold, run tracking, tree walk
    task automatic decode_tick(input logic [14:0] amp);
        int unsigned avg_next;
        int unsigned thresh;
        int unsigned dit_u;
        int unsigned run_u;
        logic tone_now;
        logic [7:0] sym;
        mtd_pkg::result_t one;
        mtd_pkg::result_t burst [$];
        avg_next = (amp_avg * 7 + amp * 8) >> 3;
        amp_avg = 18'(avg_next);
        thresh = amp_avg >> 3;
        if (thresh < floor_level)
            thresh = floor_level;
        tone_now = (amp > thresh);
        dit_u = dit_est;
        run_u = run_len;
        if (tone_now == tone_on)
        begin
            if (run_len != mtd_pkg::RUN_MAX)
                run_len = run_len + 8'd1;
        end
        else
        begin
            if (tone_on)
            begin
                // a sixth element on a full tree is dropped
                if (node < TREE_FULL)
                begin
                    if (run_u <= dit_u + (dit_u >> 1))
                    begin
                        node = {node[4:0], 1'b0};
                        dit_est = 8'((dit_u * 3 + run_u) >> 2);
                    end
                    else
                    begin
                        node = {node[4:0], 1'b1};
                        dit_est = 8'((dit_u * 3 + run_u / 3) >> 2);
                    end
                end
            end
            else if (run_u >= dit_u * 2)
            begin
                sym = mtd_pkg::TREE_SYMBOLS[node];
                if (sym != 8'd0)
                begin
                    one.character = sym[6:0];
                    one.last = 1'b0;
                    burst.push_back(one);
                end
                node = mtd_pkg::TREE_ROOT;
                // word gap adds a space even with nothing decoded
                if (run_u >= dit_u * 7)
                begin
                    one.character = mtd_pkg::CHAR_SPACE;
                    one.last = 1'b0;
                    burst.push_back(one);
                end
            end
            tone_on = tone_now;
            run_len = 8'd0;
            if (burst.size() > 0)
                burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i])
                expected_chars.push_back(burst[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_level = mtd_pkg::RESET_MIN_THRESHOLD;
            amp_avg = {mtd_pkg::RESET_MIN_THRESHOLD, 3'b000};
            dit_est = mtd_pkg::RESET_INITIAL_DIT;
            tone_on = 1'b0;
            run_len = 8'd0;
            node = mtd_pkg::TREE_ROOT;
            expected_chars.delete();
        end
        else
        begin
            // results of an item are registered in the queue before they can be taken, so drain before predicting
            if (result_valid && result_ready)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch($sformatf("unexpected character 0x%02h", character));
                else
                begin
                    want = expected_chars.pop_front();
                    if (character !== want.character)
                        report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                                  character, want.character));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %b, expected %b on 0x%02h",
                                                  last, want.last, want.character));
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    ADDR_MIN_THRESHOLD:
                    begin
                        floor_level = pwdata[14:0];
                        amp_avg = {pwdata[14:0], 3'b000};
                    end
                    ADDR_INITIAL_DIT:
                        dit_est = pwdata[7:0];
                    default: ;
                endcase
            end
            if (sample_valid && sample_ready)
                decode_tick(amplitude);
        end
        pending = expected_chars.size();
    end

endmodule

[sim/tb_morse_tone_decoder_unit.sv]
`timescale 1ns / 1ps

module tb_morse_tone_decoder_unit;
    import mtd_tb_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_PHASES   = 7;
    localparam int AMP_MAX      = 32767;

    // opening run: word gap at the root, short marks, amplitudes at the floor
    localparam int DIRECTED_STEPS = 11;
    localparam int DIRECTED_AMP [DIRECTED_STEPS] =
        '{0, 32767, 0, 32767, 0, 100, 101, 0, 32767, 16384, 0};
    localparam int DIRECTED_REPEAT [DIRECTED_STEPS] =
        '{7, 1, 3, 3, 2, 1, 2, 1, 1, 1, 3};

    typedef struct packed {
        logic [14:0] floor_level;
        logic [7:0]  dit_reg;
        logic [3:0]  sender_dit;
        logic [9:0]  ticks;
        logic        hold;
    } phase_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        sample_valid;
    logic        sample_ready;
    logic [14:0] amplitude;
    logic        result_valid;
    logic        result_ready;
    logic [6:0]  character;
    logic        last;

    int fail_count;
    int pending;
    int stuck_cycles;
    int phase_items;
    int cur_floor;
    int sender_dit;
    bit sender_steady;
    bit receiver_steady;
    bit hold_req;

    morse_tone_decoder_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .amplitude    (amplitude),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .character    (character),
        .last         (last)
    );

    morse_tone_decoder_checker char_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .amplitude    (amplitude),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .character    (character),
        .last         (last),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic phase_t phase_setting(input int idx);
        phase_t p;
        case (idx % NUM_PHASES)
            0: p = '{15'd0,     8'd1,   4'd1, 10'd100, 1'b0};
            1: p = '{15'd32767, 8'd255, 4'd3, 10'd270, 1'b0};
            2: p = '{15'd2000,  8'd3,   4'd3, 10'd110, 1'b0};
            3: p = '{15'd100,   8'd0,   4'd2, 10'd120, 1'b1};
            4: p = '{15'd20000, 8'd255, 4'd5, 10'd110, 1'b0};
            5: p = '{15'd500,   8'd12,  4'd4, 10'd100, 1'b0};
            default: p = '{15'd1, 8'd8, 4'd2, 10'd100, 1'b0};
        endcase
        return p;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_sample(input logic [14:0] amp);
        int gap;
        if ($urandom_range(31, 0) == 0)
            sender_steady = !sender_steady;
        gap = sender_steady ? 0 : $urandom_range(3, 0);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid <= 1'b1;
        amplitude <= amp;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        phase_items++;
        @(negedge clk);
    endtask

    // a run of tone or silence, with the odd full-range noise tick
    task automatic send_ticks(input bit tone, input int count);
        int k;
        logic [14:0] level;
        if (cur_floor >= AMP_MAX)
            level = 15'(AMP_MAX);
        else
            level = 15'($urandom_range(AMP_MAX, cur_floor + 1));
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(15, 0) == 0)
                send_sample(15'($urandom_range(AMP_MAX, 0)));
            else if (tone)
                send_sample(level);
            else
                send_sample(15'($urandom_range(cur_floor, 0)));
        end
    endtask

    task automatic send_letter();
        int elements;
        int e;
        int gap_pick;
        // six or seven elements overrun the tree
        if ($urandom_range(7, 0) == 0)
            elements = $urandom_range(7, 6);
        else
            elements = $urandom_range(5, 1);
        for (e = 0; e < elements; e++)
        begin
            send_ticks(1'b1, ($urandom_range(1, 0) ? 3 : 1) * sender_dit
                             + $urandom_range(1, 0));
            if (e < elements - 1)
                send_ticks(1'b0, sender_dit + $urandom_range(1, 0));
        end
        gap_pick = $urandom_range(9, 0);
        if (gap_pick < 6)
            send_ticks(1'b0, 3 * sender_dit + $urandom_range(1, 0));
        else if (gap_pick < 9)
            send_ticks(1'b0, 7 * sender_dit + $urandom_range(2, 0));
        else
            send_ticks(1'b0, $urandom_range(2, 1));
    endtask

    task automatic run_phase(input int idx);
        phase_t cfg;
        logic [31:0] noise;
        cfg = phase_setting(idx);
        sample_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        noise = $urandom;
        write_reg(ADDR_MIN_THRESHOLD, {noise[31:15], cfg.floor_level});
        write_reg(ADDR_INITIAL_DIT, {noise[31:8], cfg.dit_reg});
        cur_floor = cfg.floor_level;
        sender_dit = cfg.sender_dit;
        if (cfg.hold)
            hold_req = 1'b1;
        phase_items = 0;
        while (phase_items < cfg.ticks)
            send_letter();
    endtask

    // receiver: random stalls per item, plus a long hold-off on request
    initial
    begin
        int stall;
        int hold_left;
        result_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ready <= 1'b0;
                hold_left = HOLD_CYCLES;
                while (hold_left > 0)
                begin
                    @(negedge clk);
                    hold_left--;
                end
            end
            if ($urandom_range(31, 0) == 0)
                receiver_steady = !receiver_steady;
            stall = receiver_steady ? 0 : $urandom_range(3, 0);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready)
            || (psel && penable))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        int i;
        int phase;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_valid = 1'b0;
        amplitude = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // short dit so the opening run reaches word gaps quickly
        write_reg(ADDR_INITIAL_DIT, 32'd1);
        cur_floor = mtd_pkg::RESET_MIN_THRESHOLD;
        for (i = 0; i < DIRECTED_STEPS; i++)
            repeat (DIRECTED_REPEAT[i]) send_sample(15'(DIRECTED_AMP[i]));

        phase = 0;
        while (phase < NUM_PHASES)
        begin
            run_phase(phase);
            phase++;
        end

        sample_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
